FILE: rtl/playfair_encryptor_defines.svh
// Assertion macros shared by the Playfair encryptor RTL.
// They compile to nothing when SYNTHESIS is defined.
`ifndef PLAYFAIR_ENCRYPTOR_DEFINES_SVH
`define PLAYFAIR_ENCRYPTOR_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge out of reset.
`define PFE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("playfair_encryptor: assertion failed");

// A same-cycle implication.
`define PFE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("playfair_encryptor: implication failed");

// A next-cycle implication.
`define PFE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("playfair_encryptor: next-cycle implication failed");

`else

`define PFE_ASSERT(name, prop)
`define PFE_ASSERT_IMP(name, ante, cons)
`define PFE_ASSERT_NXT(name, ante, cons)

`endif

`endif

FILE: rtl/pfe_pkg.sv
package pfe_pkg;

  // Square geometry.
  localparam int SqSize     = 5;
  localparam int LetterW    = 5;
  localparam int PosW       = $clog2(SqSize);
  localparam int RowW       = SqSize * LetterW;

  // Pair queue between the front and the back.
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyRow0 = 3'd0,
    CfgKeyRow1 = 3'd1,
    CfgKeyRow2 = 3'd2,
    CfgKeyRow3 = 3'd3,
    CfgKeyRow4 = 3'd4,
    CfgFiller  = 3'd5,
    CfgPad     = 3'd6
  } cfg_idx_e;

  typedef logic [LetterW-1:0] letter_t;

  // Square as rows of cells; cell [r][c] sits at bits c*5 of row r.
  typedef logic [SqSize-1:0][SqSize-1:0][LetterW-1:0] key_sq_t;

  // Reset square L G D B A / Q M H E C / U R N I F / X V S O K / Z Y W T P.
  localparam logic [RowW-1:0] KeyRow0Rst = 25'd36043;
  localparam logic [RowW-1:0] KeyRow1Rst = 25'd2235792;
  localparam logic [RowW-1:0] KeyRow2Rst = 25'd5518900;
  localparam logic [RowW-1:0] KeyRow3Rst = 25'd10963639;
  localparam logic [RowW-1:0] KeyRow4Rst = 25'd16374553;
  localparam letter_t         FillerRst  = 5'd23;
  localparam letter_t         PadRst     = 5'd25;

  typedef struct packed {
    key_sq_t key;
    letter_t filler;
    letter_t pad;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } pos_t;

  typedef struct packed {
    logic found;
    pos_t pos;
  } find_t;

  typedef struct packed {
    pos_t first;
    pos_t second;
  } pair_t;

  // One queue entry: the pairs caused by one input item.
  typedef struct packed {
    logic  two_pairs;
    pair_t pair_a;
    pair_t pair_b;
  } job_t;

  typedef struct packed {
    letter_t letter;
    logic    end_of_text;
  } in_item_t;

  typedef struct packed {
    letter_t cipher_letter;
    logic    last_of_run;
  } out_item_t;

  // Position of a code in the square; first hit in row-major order wins,
  // row 0 column 0 when there is none.
  function automatic find_t find_pos(key_sq_t key, letter_t code);
    find_t res;
    res = '0;
    for (int r = SqSize - 1; r >= 0; r--) begin
      for (int c = SqSize - 1; c >= 0; c--) begin
        if (key[r][c] == code) begin
          res.found   = 1'b1;
          res.pos.row = PosW'(r);
          res.pos.col = PosW'(c);
        end
      end
    end
    return res;
  endfunction

  // Step a row or column index by one, wrapping around the square.
  function automatic logic [PosW-1:0] wrap_inc(logic [PosW-1:0] idx);
    logic [PosW-1:0] res;
    res = (idx == PosW'(SqSize - 1)) ? '0 : idx + PosW'(1);
    return res;
  endfunction

endpackage

FILE: rtl/pfe_front.sv
`include "playfair_encryptor_defines.svh"

module pfe_front import pfe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     q_full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic    pend_valid_q, pend_valid_d;
  letter_t pend_letter_q, pend_letter_d;
  pos_t    pend_pos_q, pend_pos_d;

  logic  accept;
  find_t hit;
  find_t fill_hit;
  find_t pad_hit;
  pos_t  fill_pos;
  pos_t  pad_pos;

  // The queue is the only thing that holds the front back.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Square lookups for the letter, the filler and the pad.
  // A filler or pad outside the square takes row 0, column 0.
  always_comb begin
    hit      = find_pos(cfg_i.key, in_data_i.letter);
    fill_hit = find_pos(cfg_i.key, cfg_i.filler);
    pad_hit  = find_pos(cfg_i.key, cfg_i.pad);
    fill_pos = fill_hit.found ? fill_hit.pos : '0;
    pad_pos  = pad_hit.found ? pad_hit.pos : '0;
  end

  // Digraph forming: decide which pairs this letter completes.
  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    pend_pos_d    = pend_pos_q;
    push_o        = 1'b0;
    job_o         = '0;
    if (accept) begin
      if (!hit.found) begin
        // Letter not in the square is dropped; end of text flushes the pending one.
        if (in_data_i.end_of_text && pend_valid_q) begin
          push_o       = 1'b1;
          job_o.pair_a = '{first: pend_pos_q, second: pad_pos};
          pend_valid_d = 1'b0;
        end
      end else if (!pend_valid_q) begin
        if (in_data_i.end_of_text) begin
          push_o       = 1'b1;
          job_o.pair_a = '{first: hit.pos, second: pad_pos};
        end else begin
          pend_valid_d  = 1'b1;
          pend_letter_d = in_data_i.letter;
          pend_pos_d    = hit.pos;
        end
      end else if (in_data_i.letter == pend_letter_q) begin
        // Repeated letter: filler completes the pair, the repeat opens the next.
        push_o       = 1'b1;
        job_o.pair_a = '{first: pend_pos_q, second: fill_pos};
        if (in_data_i.end_of_text) begin
          job_o.two_pairs = 1'b1;
          job_o.pair_b    = '{first: hit.pos, second: pad_pos};
          pend_valid_d    = 1'b0;
        end else begin
          pend_letter_d = in_data_i.letter;
          pend_pos_d    = hit.pos;
        end
      end else begin
        push_o       = 1'b1;
        job_o.pair_a = '{first: pend_pos_q, second: hit.pos};
        pend_valid_d = 1'b0;
      end
    end
  end

  // Pending first letter of a pair.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
      pend_pos_q    <= '0;
    end else begin
      pend_valid_q  <= pend_valid_d;
      pend_letter_q <= pend_letter_d;
      pend_pos_q    <= pend_pos_d;
    end
  end

  // A pending letter always has a position inside the square.
  `PFE_ASSERT_IMP(a_pend_in_square, pend_valid_q,
                  (pend_pos_q.row < PosW'(SqSize)) && (pend_pos_q.col < PosW'(SqSize)))

endmodule

FILE: rtl/pfe_queue.sv
`include "playfair_encryptor_defines.svh"

module pfe_queue import pfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output job_t head_data_o
);

  job_t              entries_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == QCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Occupancy tracking.
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  `PFE_ASSERT(a_count_bound, count_q <= QCntW'(QueueDepth))
  `PFE_ASSERT(a_no_overflow, !(push_i && full_o))

endmodule

FILE: rtl/pfe_back.sv
`include "playfair_encryptor_defines.svh"

module pfe_back import pfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      head_valid_i,
  input  job_t      head_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [1:0] step_q;
  logic       out_valid_q;
  out_item_t  out_q;

  logic    load;
  logic    last_step;
  pair_t   cur_pair;
  pos_t    self_pos, other_pos;
  letter_t cipher;

  // Step 0/1 are the letters of the first pair, 2/3 those of the second.
  assign cur_pair  = step_q[1] ? head_data_i.pair_b : head_data_i.pair_a;
  assign self_pos  = step_q[0] ? cur_pair.second : cur_pair.first;
  assign other_pos = step_q[0] ? cur_pair.first  : cur_pair.second;
  assign last_step = head_data_i.two_pairs ? (step_q == 2'd3) : (step_q == 2'd1);

  // Playfair rules: same row goes right, same column goes down, else swap columns.
  always_comb begin
    if (cur_pair.first.row == cur_pair.second.row) begin
      cipher = cfg_i.key[self_pos.row][wrap_inc(self_pos.col)];
    end else if (cur_pair.first.col == cur_pair.second.col) begin
      cipher = cfg_i.key[wrap_inc(self_pos.row)][self_pos.col];
    end else begin
      cipher = cfg_i.key[self_pos.row][other_pos.col];
    end
  end

  // Output register takes from the queue head whenever empty or being transferred.
  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        step_q      <= last_step ? 2'd0 : step_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= '{cipher_letter: cipher, last_of_run: last_step};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A partly emitted entry stays at the head of the queue.
  `PFE_ASSERT_IMP(a_step_has_head, step_q != 2'd0, head_valid_i)
  // A single-pair entry never reaches the second-pair steps.
  `PFE_ASSERT_IMP(a_single_steps, head_valid_i && !head_data_i.two_pairs, !step_q[1])

endmodule

FILE: rtl/playfair_encryptor.sv
// Playfair encryptor: takes one plaintext letter (A=0..Z=25) per transfer and
// returns cipher letters in digraph order, with last_of_run marking the final
// letter caused by each input. A front stage looks up the letter in the key
// square, forms pairs (filler between repeats, pad after an odd final letter,
// letters outside the square dropped) and writes one entry per productive
// letter into a four-entry pair queue. A back stage reads the square again and
// sends one cipher letter per cycle, while the output is not stalled, through
// an output register. The input takes a letter every cycle while the queue has
// room; output bandwidth is one letter per cycle, so ordinary text streams at
// one letter per cycle, and runs of repeated letters, which give two results
// each, fill the queue and then hold the input back to the output's pace. The
// results of a transfer pass through the pair queue and then the output
// register. Configuration is a plain write port and takes effect at once;
// write it only while the block is idle.
module playfair_encryptor import pfe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [RowW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o
);

  cfg_t cfg_q;
  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key[0] <= KeyRow0Rst;
      cfg_q.key[1] <= KeyRow1Rst;
      cfg_q.key[2] <= KeyRow2Rst;
      cfg_q.key[3] <= KeyRow3Rst;
      cfg_q.key[4] <= KeyRow4Rst;
      cfg_q.filler <= FillerRst;
      cfg_q.pad    <= PadRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        CfgKeyRow0, CfgKeyRow1, CfgKeyRow2, CfgKeyRow3, CfgKeyRow4: begin
          cfg_q.key[cfg_idx_i] <= cfg_wdata_i;
        end
        CfgFiller: begin
          cfg_q.filler <= cfg_wdata_i[LetterW-1:0];
        end
        CfgPad: begin
          cfg_q.pad <= cfg_wdata_i[LetterW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  pfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  pfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_job)
  );

  pfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_data_i  (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
